// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16LE transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned REPORT_W = 32;
    localparam int unsigned ACC_W    = 21;
    localparam int unsigned MAX_RES  = 3;
    localparam int unsigned Q_DEPTH  = 4;

    // Lead and continuation byte classes.
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] ASCII_LIM = 8'h80;
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD_LIM  = 8'hF5;

    // Code point range limits.
    localparam logic [ACC_W-1:0] CP3_MIN = 21'h000800;
    localparam logic [ACC_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [ACC_W-1:0] SURR_HI = 21'h00E000;
    localparam logic [ACC_W-1:0] CP4_MIN = 21'h010000;
    localparam logic [ACC_W-1:0] CP_MAX  = 21'h10FFFF;

    // Surrogate pair construction.
    localparam logic [UNIT_W-1:0] HI_SURR_OFS = 16'hD7C0;
    localparam logic [UNIT_W-1:0] LO_SURR_TAG = 16'hDC00;

    // Sequence length codes.
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_value;
        logic                is_status;
        logic                status_code;
        logic [REPORT_W-1:0] bytes_consumed;
        logic [REPORT_W-1:0] units_written;
        logic                last_result;
    } t_res;

    // All results caused by one input byte, oldest in item 0.
    typedef struct packed {
        logic [1:0]               count;
        t_res [MAX_RES-1:0]       items;
    } t_bundle;

endpackage

`default_nettype wire

// ===== rtl/u8u16_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Input byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8u16_res_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_res_if
// Result channel carrying UTF-16 units and the final status word.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit_value;
    logic        is_status;
    logic        status_code;
    logic [31:0] bytes_consumed;
    logic [31:0] units_written;
    logic        last_result;

    modport source (
        output valid, output unit_value, output is_status, output status_code,
        output bytes_consumed, output units_written, output last_result,
        input ready
    );
    modport sink (
        input valid, input unit_value, input is_status, input status_code,
        input bytes_consumed, input units_written, input last_result,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/utf8_to_utf16le_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16le_transcoder_unit
// Validating UTF-8 to UTF-16LE transcoder, one input byte per cycle while ready.
// ----------------------------------------------------------------------------
// The unit takes one UTF-8 byte per clock while ready and emits at most one
// word per clock on the result channel. A byte that completes a one-, two- or
// three-byte sequence yields one UTF-16 unit, a byte that completes a
// four-byte sequence yields a surrogate pair, and the byte flagged as last
// adds a status word carrying the stop offset and the unit count; every other
// byte yields nothing. The words caused by one byte go into a four-entry
// result queue together, and the input is ready whenever that queue holds at
// most one word, so with a word taken every cycle the unit takes one byte per
// cycle unless a byte yields two or three words, which holds the input off
// while the queue drains; that single result port sets the rate. The first
// invalid or truncated sequence stops conversion, and later bytes are counted
// but silent until the last byte of the buffer, after which all sequence state
// and counters return to zero for the next buffer. Counters are COUNT_WIDTH
// bits wide and wrap; the reported counts are their low 32 bits. With no older
// word queued, a byte's first result appears on the port right after the edge
// that takes the byte and can be taken at the following edge.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16le_transcoder_unit #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    u8u16_byte_if.sink         i_in,
    u8u16_res_if.source        o_out
);
    import u8u16_pkg::*;

    logic    accept;
    logic    q_ready;
    logic    q_valid;
    t_bundle bundle;
    t_res    head;

    // A byte is taken whenever the queue can absorb a worst-case bundle.
    assign i_in.ready = q_ready;
    assign accept     = i_in.valid && q_ready;

    // Decode the byte against the open sequence and build its result bundle.
    u8u16_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in.in_byte),
        .i_last_byte (i_in.last_byte),
        .o_bundle    (bundle)
    );

    // The queue registers every result and separates the two handshakes.
    u8u16_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_bundle (bundle),
        .i_pop    (o_out.ready),
        .o_ready  (q_ready),
        .o_valid  (q_valid),
        .o_head   (head)
    );

    assign o_out.valid          = q_valid;
    assign o_out.unit_value     = head.unit_value;
    assign o_out.is_status      = head.is_status;
    assign o_out.status_code    = head.status_code;
    assign o_out.bytes_consumed = head.bytes_consumed;
    assign o_out.units_written  = head.units_written;
    assign o_out.last_result    = head.last_result;

endmodule

`default_nettype wire

// ===== rtl/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and per-byte decode into a bundle of up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic               i_last_byte,
    output u8u16_pkg::t_bundle      o_bundle
);
    import u8u16_pkg::*;

    localparam int unsigned EXT_W = (COUNT_WIDTH > REPORT_W) ? COUNT_WIDTH : REPORT_W;

    logic [ACC_W-1:0]       r_acc,    n_acc;
    logic [1:0]             r_pend,   n_pend;
    logic [2:0]             r_slen,   n_slen;
    logic [COUNT_WIDTH-1:0] r_bcnt,   n_bcnt;
    logic [COUNT_WIDTH-1:0] r_sstart, n_sstart;
    logic [COUNT_WIDTH-1:0] r_ucnt,   n_ucnt;
    logic                   r_err,    n_err;

    logic [ACC_W-1:0]  cp;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic [1:0]        nunits;
    logic              fin_err;
    logic [EXT_W-1:0]  bytes_ext;
    logic [EXT_W-1:0]  units_ext;
    logic [1:0]        res_cnt;

    always_comb begin
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_slen   = r_slen;
        n_sstart = r_sstart;
        n_err    = r_err;
        cp       = '0;
        unit0    = '0;
        unit1    = '0;
        nunits   = 2'd0;

        if (!r_err) begin
            if (r_pend != 2'd0) begin
                if ((i_in_byte & CONT_MASK) == CONT_TAG) begin
                    cp     = {r_acc[ACC_W-7:0], i_in_byte[5:0]};
                    n_acc  = cp;
                    n_pend = r_pend - 2'd1;
                    if (n_pend == 2'd0) begin
                        if (r_slen == SEQ_TWO) begin
                            unit0  = cp[UNIT_W-1:0];
                            nunits = 2'd1;
                        end else if (r_slen == SEQ_THREE) begin
                            if (cp < CP3_MIN || (cp >= SURR_LO && cp < SURR_HI)) begin
                                n_err = 1'b1;
                            end else begin
                                unit0  = cp[UNIT_W-1:0];
                                nunits = 2'd1;
                            end
                        end else begin
                            if (cp < CP4_MIN || cp > CP_MAX) begin
                                n_err = 1'b1;
                            end else begin
                                unit0  = HI_SURR_OFS + UNIT_W'(cp[ACC_W-1:10]);
                                unit1  = LO_SURR_TAG | {6'd0, cp[9:0]};
                                nunits = 2'd2;
                            end
                        end
                        if (!n_err) begin
                            n_slen = SEQ_NONE;
                        end
                    end
                end else begin
                    n_err = 1'b1;
                end
            end else begin
                n_sstart = r_bcnt;
                priority if (i_in_byte < ASCII_LIM) begin
                    unit0  = {8'd0, i_in_byte};
                    nunits = 2'd1;
                end else if (i_in_byte < LEAD2_MIN) begin
                    n_err = 1'b1;
                end else if (i_in_byte < LEAD3_MIN) begin
                    n_slen = SEQ_TWO;
                    n_pend = 2'd1;
                    n_acc  = {16'd0, i_in_byte[4:0]};
                end else if (i_in_byte < LEAD4_MIN) begin
                    n_slen = SEQ_THREE;
                    n_pend = 2'd2;
                    n_acc  = {17'd0, i_in_byte[3:0]};
                end else if (i_in_byte < LEAD_LIM) begin
                    n_slen = SEQ_FOUR;
                    n_pend = 2'd3;
                    n_acc  = {18'd0, i_in_byte[2:0]};
                end else begin
                    n_err = 1'b1;
                end
            end
        end

        n_bcnt = r_bcnt + COUNT_WIDTH'(1);
        n_ucnt = r_ucnt + COUNT_WIDTH'(nunits);

        // A sequence still open at the end of the buffer counts as truncated.
        fin_err   = n_err | (n_pend != 2'd0);
        bytes_ext = EXT_W'(fin_err ? n_sstart : n_bcnt);
        units_ext = EXT_W'(n_ucnt);
        res_cnt   = nunits + {1'b0, i_last_byte};

        o_bundle       = '0;
        o_bundle.count = res_cnt;
        if (nunits != 2'd0) begin
            o_bundle.items[0].unit_value = unit0;
        end
        if (nunits == 2'd2) begin
            o_bundle.items[1].unit_value = unit1;
        end
        if (i_last_byte) begin
            o_bundle.items[nunits].is_status      = 1'b1;
            o_bundle.items[nunits].status_code    = fin_err;
            o_bundle.items[nunits].bytes_consumed = bytes_ext[REPORT_W-1:0];
            o_bundle.items[nunits].units_written  = units_ext[REPORT_W-1:0];
        end
        if (res_cnt != 2'd0) begin
            o_bundle.items[res_cnt - 2'd1].last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pend   <= '0;
            r_slen   <= SEQ_NONE;
            r_bcnt   <= '0;
            r_sstart <= '0;
            r_ucnt   <= '0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_acc    <= '0;
                r_pend   <= '0;
                r_slen   <= SEQ_NONE;
                r_bcnt   <= '0;
                r_sstart <= '0;
                r_ucnt   <= '0;
                r_err    <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_pend   <= n_pend;
                r_slen   <= n_slen;
                r_bcnt   <= n_bcnt;
                r_sstart <= n_sstart;
                r_ucnt   <= n_ucnt;
                r_err    <= n_err;
            end
        end
    end

    // The last byte of a buffer always leaves the decoder in its reset state.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=> r_pend == 2'd0 && !r_err && r_bcnt == '0 && r_ucnt == '0)
        else $error("decoder state not cleared after last byte");

    // Continuations still owed are always fewer than the sequence length.
    a_pend_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd0 |-> {1'b0, r_pend} < r_slen)
        else $error("pending continuations exceed sequence length");

endmodule

`default_nettype wire

// ===== rtl/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Four-entry result queue; takes a whole bundle, drains one word a cycle on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire u8u16_pkg::t_bundle i_bundle,
    input  wire logic               i_pop,
    output logic                    o_ready,
    output logic                    o_valid,
    output u8u16_pkg::t_res         o_head
);
    import u8u16_pkg::*;

    localparam int unsigned IDX_W = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    t_res [Q_DEPTH-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               pop;
    logic [CNT_W-1:0]   base;
    logic [IDX_W-1:0]   wr_idx;

    assign pop     = i_pop && (r_cnt != '0);
    // Room for a full bundle of three whenever at most one word is held.
    assign o_ready = (r_cnt <= CNT_W'(1));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[0];

    always_comb begin
        base   = r_cnt - CNT_W'(pop);
        n_slot = r_slot;
        wr_idx = '0;
        if (pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_slot[i] = r_slot[i+1];
            end
        end
        if (i_push) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < i_bundle.count) begin
                    wr_idx         = base[IDX_W-1:0] + IDX_W'(k);
                    n_slot[wr_idx] = i_bundle.items[k];
                end
            end
        end
        n_cnt = base + (i_push ? CNT_W'(i_bundle.count) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt <= CNT_W'(1))
        else $error("bundle pushed without room");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_head.is_status |-> o_head.last_result)
        else $error("status word not marked as last result");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UTF-16LE transcoder unit.
// ----------------------------------------------------------------------------
// A short directed table walks the code point extremes and several kinds of
// ill-formed input. Random byte buffers follow, built mostly from well-formed
// sequences with broken ones mixed in. Every word taken on the byte channel
// runs through a transcoding model kept in this file. The model queues the
// result words it predicts, and each word leaving the unit is checked field
// by field against the oldest one in that queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int unsigned RANDOM_BYTES = 95;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned SETTLE_TIME  = 8;

    // Status codes reported in the final word of a buffer.
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_STOPPED = 1'b1;

    // Stall patterns of the result side.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT_STALL,
        RX_EVERY_THIRD,
        RX_HEAVY_STALL
    } rx_mode_e;

    // Kinds of sequence that the random buffer builder strings together.
    typedef enum logic [3:0] {
        K_ASCII,
        K_TWO,
        K_THREE,
        K_FOUR,
        K_NOISE,
        K_BAD_FORM,
        K_CUT,
        K_BAD_LEAD,
        K_STRAY
    } seq_kind_e;

    // One row of the directed table. Where typed is set, word is the one
    // result the byte must cause and it replaces the model's prediction.
    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        t_res       word;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8u16_byte_if byte_ch ();
    u8u16_res_if  res_ch ();

    utf8_to_utf16le_transcoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Side information that travels with each byte on the channel, so the
    // monitor knows at the moment of acceptance whether a typed expectation
    // applies.
    logic drv_typed;
    t_res drv_word;

    // Transcoder model state.
    logic [ACC_W-1:0] acc_cp;
    logic [1:0]       cont_left;
    logic [2:0]       seq_len;
    logic [31:0]      bytes_seen;
    logic [31:0]      lead_offset;
    logic [31:0]      units_out;
    logic             stopped;

    t_res expected_words[$];
    t_res step_words[$];

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;

    // Set by the byte side to ask the result side for one long hold-off.
    bit hold_req = 1'b0;

    logic [7:0] buf_q[$];
    int unsigned burst_left = 0;

    // ------------------------------------------------------------------------
    // Transcoding model
    // ------------------------------------------------------------------------

    task automatic reset_model();
        acc_cp      = '0;
        cont_left   = '0;
        seq_len     = SEQ_NONE;
        bytes_seen  = '0;
        lead_offset = '0;
        units_out   = '0;
        stopped     = 1'b0;
    endtask

    task automatic emit_unit(input logic [UNIT_W-1:0] v);
        t_res w;
        w = '0;
        w.unit_value = v;
        step_words.push_back(w);
        units_out = units_out + 32'd1;
    endtask

    // Works out every word that one accepted byte causes and queues them,
    // with last_result set on the final one.
    task automatic transcode_byte(input logic [7:0] b, input logic last,
                                  input logic typed, input t_res typed_word);
        t_res             w;
        logic [ACC_W-1:0] cp;
        int               i;
        step_words.delete();
        if (!stopped) begin
            if (cont_left != 2'd0) begin
                if ((b & CONT_MASK) == CONT_TAG) begin
                    cp = {acc_cp[ACC_W-7:0], b[5:0]};
                    acc_cp = cp;
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        // The range checks only happen once the sequence is
                        // complete; a failure is charged to its lead byte.
                        if (seq_len == SEQ_TWO) begin
                            emit_unit(cp[UNIT_W-1:0]);
                        end else if (seq_len == SEQ_THREE) begin
                            if (cp < CP3_MIN || (cp >= SURR_LO && cp < SURR_HI)) begin
                                stopped = 1'b1;
                            end else begin
                                emit_unit(cp[UNIT_W-1:0]);
                            end
                        end else if (cp < CP4_MIN || cp > CP_MAX) begin
                            stopped = 1'b1;
                        end else begin
                            emit_unit(UNIT_W'(cp[20:10]) + HI_SURR_OFS);
                            emit_unit(LO_SURR_TAG | UNIT_W'(cp[9:0]));
                        end
                        if (!stopped) begin
                            seq_len = SEQ_NONE;
                        end
                    end
                end else begin
                    // A missing continuation stops at the open sequence.
                    stopped = 1'b1;
                end
            end else begin
                lead_offset = bytes_seen;
                if (b < ASCII_LIM) begin
                    emit_unit({8'h00, b});
                end else if (b < LEAD2_MIN) begin
                    // Stray continuation or a C0/C1 lead.
                    stopped = 1'b1;
                end else if (b < LEAD3_MIN) begin
                    seq_len   = SEQ_TWO;
                    cont_left = 2'd1;
                    acc_cp    = ACC_W'(b[4:0]);
                end else if (b < LEAD4_MIN) begin
                    seq_len   = SEQ_THREE;
                    cont_left = 2'd2;
                    acc_cp    = ACC_W'(b[3:0]);
                end else if (b < LEAD_LIM) begin
                    seq_len   = SEQ_FOUR;
                    cont_left = 2'd3;
                    acc_cp    = ACC_W'(b[2:0]);
                end else begin
                    stopped = 1'b1;
                end
            end
        end
        bytes_seen = bytes_seen + 32'd1;
        if (last) begin
            // A sequence still open at the end of the buffer is truncated.
            if (!stopped && cont_left != 2'd0) begin
                stopped = 1'b1;
            end
            w = '0;
            w.is_status      = 1'b1;
            w.status_code    = stopped ? ST_STOPPED : ST_OK;
            w.bytes_consumed = stopped ? lead_offset : bytes_seen;
            w.units_written  = units_out;
            step_words.push_back(w);
            reset_model();
        end
        if (typed) begin
            step_words.delete();
            step_words.push_back(typed_word);
        end
        for (i = 0; i < step_words.size(); i++) begin
            w = step_words[i];
            w.last_result = (i == step_words.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        t_res want;
        if (expected_words.size() == 0) begin
            $display("%0t ns: result word with nothing expected, unit %h status %b",
                     $time, res_ch.unit_value, res_ch.is_status);
            mismatches++;
        end else begin
            want = expected_words.pop_front();
            cmp_field("unit_value", 32'(want.unit_value), 32'(res_ch.unit_value));
            cmp_field("is_status", 32'(want.is_status), 32'(res_ch.is_status));
            cmp_field("status_code", 32'(want.status_code), 32'(res_ch.status_code));
            cmp_field("bytes_consumed", want.bytes_consumed, res_ch.bytes_consumed);
            cmp_field("units_written", want.units_written, res_ch.units_written);
            cmp_field("last_result", 32'(want.last_result), 32'(res_ch.last_result));
        end
    endtask

    // Both channels are sampled at the rising edge. The output side is
    // checked before the input side is predicted, so the word predicted at
    // this edge can never be matched at the same edge. The watchdog counts
    // edges at which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                check_word();
            end
            if (byte_ch.valid && byte_ch.ready) begin
                transcode_byte(byte_ch.in_byte, byte_ch.last_byte, drv_typed, drv_word);
            end
            if ((res_ch.valid && res_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: changes ready at the falling edge, switching between stall
    // patterns at random. One long hold-off is served on request so that the
    // unit's result queue fills and the byte side backs up.
    // ------------------------------------------------------------------------
    initial begin
        rx_mode_e    rx_mode;
        int unsigned seg_left;
        int unsigned tick;
        rx_mode  = RX_OPEN;
        seg_left = 0;
        tick     = 0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (seg_left == 0) begin
                rx_mode  = rx_mode_e'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            tick++;
            case (rx_mode)
                RX_OPEN:        res_ch.ready <= 1'b1;
                RX_LIGHT_STALL: res_ch.ready <= ($urandom_range(0, 9) < 7);
                RX_EVERY_THIRD: res_ch.ready <= (tick % 3 != 0);
                default:        res_ch.ready <= ($urandom_range(0, 9) < 4);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after acceptance,
    // leaving valid high so back-to-back words need no second assignment.
    task automatic send_word(input logic [7:0] b, input logic last,
                             input logic typed, input t_res w);
        byte_ch.valid     <= 1'b1;
        byte_ch.in_byte   <= b;
        byte_ch.last_byte <= last;
        drv_typed         <= typed;
        drv_word          <= w;
        do begin
            @(posedge i_clk);
        end while (!byte_ch.ready);
        @(negedge i_clk);
    endtask

    // Unless steady, bytes come in bursts of random length; a new burst may start
    // right away or after a short gap with valid low.
    task automatic pace(input bit steady);
        int unsigned gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    byte_ch.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_res unit_word(input logic [UNIT_W-1:0] v);
        t_res w;
        w = '0;
        w.unit_value  = v;
        w.last_result = 1'b1;
        return w;
    endfunction

    function automatic t_res status_word(input logic code, input logic [31:0] consumed,
                                         input logic [31:0] written);
        t_res w;
        w = '0;
        w.is_status      = 1'b1;
        w.status_code    = code;
        w.bytes_consumed = consumed;
        w.units_written  = written;
        w.last_result    = 1'b1;
        return w;
    endfunction

    // UTF-8 encoding of cp in len bytes, appended to the buffer. The length
    // is free, so overlong and out-of-range forms come out of it as well.
    task automatic put_seq(input logic [20:0] cp, input int unsigned len);
        case (len)
            1: buf_q.push_back(cp[7:0]);
            2: begin
                buf_q.push_back({3'b110, cp[10:6]});
                buf_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                buf_q.push_back({4'b1110, cp[15:12]});
                buf_q.push_back({2'b10, cp[11:6]});
                buf_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                buf_q.push_back({5'b11110, cp[20:18]});
                buf_q.push_back({2'b10, cp[17:12]});
                buf_q.push_back({2'b10, cp[11:6]});
                buf_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] valid_cp(input int unsigned len);
        logic [20:0] cp;
        case (len)
            1: cp = 21'($urandom_range(0, 8'h7F));
            2: cp = 21'($urandom_range(12'h080, 12'h7FF));
            3: begin
                cp = 21'($urandom_range(16'h0800, 16'hFFFF));
                // Move surrogate values up into the U+F800 block.
                if (cp >= SURR_LO && cp < SURR_HI) begin
                    cp = cp ^ 21'h002000;
                end
            end
            default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
        endcase
        return cp;
    endfunction

    function automatic seq_kind_e pick_kind();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 4) return K_ASCII;
        if (r < 7) return K_TWO;
        if (r < 10) return K_THREE;
        if (r < 13) return K_FOUR;
        if (r < 14) return K_NOISE;
        if (r < 16) return K_BAD_FORM;
        if (r < 17) return K_CUT;
        if (r < 18) return K_BAD_LEAD;
        if (r < 19) return K_STRAY;
        return K_ASCII;
    endfunction

    // Fills buf_q with one buffer of nseq sequences. Most are well formed, so
    // conversion usually runs deep into the buffer before any error.
    task automatic build_buffer(input int unsigned nseq);
        int unsigned k;
        int unsigned len;
        int unsigned r;
        buf_q.delete();
        for (k = 0; k < nseq; k++) begin
            case (pick_kind())
                K_ASCII:  put_seq(valid_cp(1), 1);
                K_TWO:    put_seq(valid_cp(2), 2);
                K_THREE:  put_seq(valid_cp(3), 3);
                K_FOUR:   put_seq(valid_cp(4), 4);
                K_NOISE:  buf_q.push_back(8'($urandom_range(0, 255)));
                K_BAD_FORM: begin
                    case ($urandom_range(0, 3))
                        0: put_seq(21'($urandom_range(0, 12'h7FF)), 3);
                        1: put_seq(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
                        2: put_seq(21'($urandom_range(0, 16'hFFFF)), 4);
                        default: put_seq(21'($urandom_range(21'h110000, 21'h13FFFF)), 4);
                    endcase
                end
                K_CUT: begin
                    // Drops the tail of a sequence: a missing continuation
                    // mid-buffer, or a truncation at its end.
                    len = $urandom_range(2, 4);
                    put_seq(valid_cp(len), len);
                    repeat ($urandom_range(1, len - 1)) void'(buf_q.pop_back());
                end
                K_BAD_LEAD: begin
                    r = $urandom_range(0, 12);
                    buf_q.push_back(r < 2 ? 8'hC0 + 8'(r) : 8'hF5 + 8'(r - 2));
                end
                default: buf_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        dir_row_t    dir_rows[$];
        int unsigned i;
        int unsigned nbuf;
        int unsigned rand_sent;
        bit          steady;

        byte_ch.valid     = 1'b0;
        byte_ch.in_byte   = 8'h00;
        byte_ch.last_byte = 1'b0;
        drv_typed         = 1'b0;
        drv_word          = '0;
        i_rst_n           = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed buffers: the first one runs from U+0000 up to U+10FFFF
        // through every sequence length, each later one stops on a
        // different kind of ill-formed input.
        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, unit_word(16'h0000)},
            '{8'h7F, 1'b0, 1'b1, unit_word(16'h007F)},
            '{8'hDF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hEF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hF4, 1'b0, 1'b0, '0},
            '{8'h8F, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b1, 1'b0, '0},
            // C0 lead alone.
            '{8'hC0, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)},
            // Stray continuation.
            '{8'h80, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)},
            // F5 lead, then a byte that is only counted.
            '{8'hF5, 1'b0, 1'b0, '0},
            '{8'h41, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)},
            // Missing continuation.
            '{8'hE0, 1'b0, 1'b0, '0},
            '{8'h41, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)},
            // Overlong four-byte form of U+FFFF.
            '{8'hF0, 1'b0, 1'b0, '0},
            '{8'h8F, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)},
            // Encoded surrogate U+D800.
            '{8'hED, 1'b0, 1'b0, '0},
            '{8'hA0, 1'b0, 1'b0, '0},
            '{8'h80, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)},
            // Two-byte lead truncated by the end of the buffer.
            '{8'hC2, 1'b1, 1'b1, status_word(ST_STOPPED, 32'd0, 32'd0)}
        };
        for (i = 0; i < dir_rows.size(); i++) begin
            pace(1'b0);
            send_word(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].word);
        end
        wait_drained();

        // Random buffers until enough bytes have gone in.
        nbuf      = 0;
        rand_sent = 0;
        while (rand_sent < RANDOM_BYTES) begin
            steady = (nbuf == 2);
            if (steady) begin
                // Long result-side hold-off while bytes keep coming.
                hold_req = 1'b1;
                build_buffer(8);
            end else begin
                build_buffer($urandom_range(1, 6));
            end
            if (nbuf == 5) begin
                // Let the unit empty out completely before this buffer.
                wait_drained();
            end
            for (i = 0; i < buf_q.size(); i++) begin
                pace(steady);
                send_word(buf_q[i], i == buf_q.size() - 1, 1'b0, '0);
            end
            rand_sent += buf_q.size();
            nbuf++;
        end

        wait_drained();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
